// ===== rtl/spq_pkg.sv =====
// shared types and constants of the stable priority queue
package spq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ID_W        = 16;
    localparam int PRIO_W      = 8;
    localparam int STATUS_W    = 2;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 32;

    typedef enum logic [STATUS_W-1:0] {
        ST_ENQUEUED = 2'd0,
        ST_FULL     = 2'd1,
        ST_DEQUEUED = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    typedef enum logic {
        MODE_ENQUEUE = 1'b0,
        MODE_DEQUEUE = 1'b1
    } mode_t;

    typedef struct packed {
        logic              occupied;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } entry_t;

    typedef struct packed {
        logic              enq;
        logic              deq;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } cell_ctl_t;

endpackage

// ===== rtl/spq_cell.sv =====
// one slot of the sorted queue: holds an entry and shifts with its neighbors
module spq_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  spq_pkg::cell_ctl_t ctl,
    input  spq_pkg::entry_t    left_entry,
    input  logic               left_lower,
    input  spq_pkg::entry_t    right_entry,
    output spq_pkg::entry_t    entry,
    output logic               lower
);

    logic                       occupied_reg;
    logic                       occupied_next;
    logic [spq_pkg::ID_W-1:0]   id_reg;
    logic [spq_pkg::ID_W-1:0]   id_next;
    logic [spq_pkg::PRIO_W-1:0] prio_reg;
    logic [spq_pkg::PRIO_W-1:0] prio_next;

    // slot is free or holds a strictly lower priority than the new entry
    assign lower = !occupied_reg || (prio_reg < ctl.prio);

    assign entry.occupied = occupied_reg;
    assign entry.id       = id_reg;
    assign entry.prio     = prio_reg;

    always_comb
    begin
        occupied_next = occupied_reg;
        id_next       = id_reg;
        prio_next     = prio_reg;
        if (ctl.enq)
        begin
            if (left_lower)
            begin
                occupied_next = left_entry.occupied;
                id_next       = left_entry.id;
                prio_next     = left_entry.prio;
            end
            else if (lower)
            begin
                occupied_next = 1'b1;
                id_next       = ctl.id;
                prio_next     = ctl.prio;
            end
        end
        else if (ctl.deq)
        begin
            occupied_next = right_entry.occupied;
            id_next       = right_entry.id;
            prio_next     = right_entry.prio;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occupied_reg <= 1'b0;
        end
        else
        begin
            occupied_reg <= occupied_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg   <= id_next;
        prio_reg <= prio_next;
    end

endmodule

// ===== rtl/stable_priority_queue_core.sv =====
// top level of the stable priority queue: row of slot cells and result register
// usage
//   s_axis carries one operation per beat: enqueue an id with a priority, or
//   dequeue the front entry. m_axis returns exactly one result beat per
//   operation: enqueued, full and dropped, dequeued with id and priority, or
//   empty. equal priorities leave in arrival order.
// latency and throughput
//   the result of a beat accepted at one edge is valid from the next cycle.
//   all slots compare against the new priority in parallel and shift by one
//   place in the same cycle, so one operation is taken every cycle unless stalled.
// reset
//   rst_n clears the occupancy of every slot and the result valid flag; the
//   queue is empty at once; ids, priorities and result data are not cleared.
// stall
//   a single result register sits on m_axis; while it holds an untaken
//   result and m_axis_tready is low, s_axis_tready is low too.
module stable_priority_queue_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // mode, item_id, item_priority, zero fill
    input  logic [spq_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status, out_id, out_priority, zero fill
    output logic [spq_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int D = spq_pkg::QUEUE_DEPTH;

    spq_pkg::entry_t            cell_entry [D];
    logic [D-1:0]               cell_lower;
    logic [D-1:0]               occ_vec;
    spq_pkg::cell_ctl_t         ctl;
    spq_pkg::entry_t            empty_entry;

    logic                       in_beat;
    spq_pkg::mode_t             in_mode;
    logic [spq_pkg::ID_W-1:0]   in_id;
    logic [spq_pkg::PRIO_W-1:0] in_prio;
    logic                       q_full;
    logic                       q_empty;

    logic                         out_valid_reg;
    logic                         out_valid_next;
    spq_pkg::status_t             out_status_reg;
    spq_pkg::status_t             out_status_next;
    logic [spq_pkg::ID_W-1:0]     out_id_reg;
    logic [spq_pkg::ID_W-1:0]     out_id_next;
    logic [spq_pkg::PRIO_W-1:0]   out_prio_reg;
    logic [spq_pkg::PRIO_W-1:0]   out_prio_next;

    assign in_mode = spq_pkg::mode_t'(s_axis_tdata[0]);
    assign in_id   = s_axis_tdata[spq_pkg::ID_W:1];
    assign in_prio = s_axis_tdata[spq_pkg::ID_W+spq_pkg::PRIO_W:spq_pkg::ID_W+1];

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    assign q_empty = !cell_entry[0].occupied;
    assign q_full  = cell_entry[D-1].occupied;

    assign ctl.enq  = in_beat && (in_mode == spq_pkg::MODE_ENQUEUE) && !q_full;
    assign ctl.deq  = in_beat && (in_mode == spq_pkg::MODE_DEQUEUE) && !q_empty;
    assign ctl.id   = in_id;
    assign ctl.prio = in_prio;

    assign empty_entry = '{occupied: 1'b0, id: '0, prio: '0};

    genvar g;
    generate
        for (g = 0; g < D; g++)
        begin : g_cell
            spq_pkg::entry_t left_e;
            spq_pkg::entry_t right_e;
            logic            left_l;
            if (g == 0)
            begin : g_head
                assign left_e = empty_entry;
                assign left_l = 1'b0;
            end
            else
            begin : g_body
                assign left_e = cell_entry[g-1];
                assign left_l = cell_lower[g-1];
            end
            if (g == D - 1)
            begin : g_tail
                assign right_e = empty_entry;
            end
            else
            begin : g_inner
                assign right_e = cell_entry[g+1];
            end
            spq_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctl         (ctl),
                .left_entry  (left_e),
                .left_lower  (left_l),
                .right_entry (right_e),
                .entry       (cell_entry[g]),
                .lower       (cell_lower[g])
            );
            assign occ_vec[g] = cell_entry[g].occupied;
        end
    endgenerate

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_id_next     = out_id_reg;
        out_prio_next   = out_prio_reg;
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (in_beat)
        begin
            out_valid_next = 1'b1;
            out_id_next    = '0;
            out_prio_next  = '0;
            if (in_mode == spq_pkg::MODE_ENQUEUE)
            begin
                out_status_next = q_full ? spq_pkg::ST_FULL : spq_pkg::ST_ENQUEUED;
            end
            else if (q_empty)
            begin
                out_status_next = spq_pkg::ST_EMPTY;
            end
            else
            begin
                out_status_next = spq_pkg::ST_DEQUEUED;
                out_id_next     = cell_entry[0].id;
                out_prio_next   = cell_entry[0].prio;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_id_reg     <= out_id_next;
        out_prio_reg   <= out_prio_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {
        {(spq_pkg::OUT_TDATA_W - spq_pkg::STATUS_W - spq_pkg::ID_W - spq_pkg::PRIO_W){1'b0}},
        out_prio_reg, out_id_reg, out_status_reg
    };

`ifndef NO_ASSERTIONS
    logic sorted_ok;
    logic [D-1:0] occ_plus;

    assign occ_plus = occ_vec + {{(D-1){1'b0}}, 1'b1};

    always_comb
    begin
        sorted_ok = 1'b1;
        for (int i = 1; i < D; i++)
        begin
            if (cell_entry[i].occupied && (cell_entry[i].prio > cell_entry[i-1].prio))
            begin
                sorted_ok = 1'b0;
            end
        end
    end

    // occupied slots form one run from the front
    a_occ_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (occ_vec & occ_plus) == '0)
        else $error("occupied slots not contiguous");

    // stored priorities never increase toward the back
    a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        sorted_ok)
        else $error("queue order broken");

    // a dropped enqueue leaves the occupancy untouched
    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (in_beat && (in_mode == spq_pkg::MODE_ENQUEUE) && q_full) |=>
            (out_status_reg == spq_pkg::ST_FULL) && $stable(occ_vec))
        else $error("full enqueue changed the queue");
`endif

endmodule

// ===== test/testbench.sv =====
// testbench of the stable priority queue: directed table, random operations, result checker
`timescale 1ns / 1ps

module testbench;
    import spq_pkg::*;

    typedef struct packed {
        status_t           status;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } queue_result_t;

    typedef struct {
        mode_t             mode;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
        bit                fixed;
        queue_result_t     want;
    } op_row_t;

    localparam int DIRECTED_ROWS = 25;
    localparam int RANDOM_ITEMS  = 1325;
    localparam int PENDING_DEPTH = 64;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    logic [ID_W-1:0]   model_id   [QUEUE_DEPTH];
    logic [PRIO_W-1:0] model_prio [QUEUE_DEPTH];
    int                model_fill;

    queue_result_t pending_results [PENDING_DEPTH];
    int            pending_wr;
    int            pending_rd;
    int            mismatch_count;
    bit            idle_on;
    int            stall_left;
    bit            beat_fixed;
    queue_result_t beat_want;

    op_row_t directed_rows [DIRECTED_ROWS] = '{
        '{MODE_DEQUEUE, 16'h0000, 8'h00, 1'b1, '{ST_EMPTY,    16'h0000, 8'h00}},
        '{MODE_ENQUEUE, 16'hFFFF, 8'hFF, 1'b1, '{ST_ENQUEUED, 16'h0000, 8'h00}},
        '{MODE_ENQUEUE, 16'h0000, 8'h00, 1'b1, '{ST_ENQUEUED, 16'h0000, 8'h00}},
        '{MODE_ENQUEUE, 16'h1234, 8'hFF, 1'b1, '{ST_ENQUEUED, 16'h0000, 8'h00}},
        '{MODE_DEQUEUE, 16'hAAAA, 8'h55, 1'b1, '{ST_DEQUEUED, 16'hFFFF, 8'hFF}},
        '{MODE_DEQUEUE, 16'h5555, 8'hAA, 1'b1, '{ST_DEQUEUED, 16'h1234, 8'hFF}},
        '{MODE_DEQUEUE, 16'hFFFF, 8'hFF, 1'b1, '{ST_DEQUEUED, 16'h0000, 8'h00}},
        '{MODE_DEQUEUE, 16'hFFFF, 8'hFF, 1'b1, '{ST_EMPTY,    16'h0000, 8'h00}},
        '{MODE_ENQUEUE, 16'h0001, 8'h80, 1'b0, '{ST_ENQUEUED, 16'h0000, 8'h00}},
        '{MODE_ENQUEUE, 16'h0002, 8'h80, 1'b0, '{ST_ENQUEUED, 16'h0000, 8'h00}},
        '{MODE_ENQUEUE, 16'h0004, 8'h01, 1'b0, '{ST_ENQUEUED, 16'h0000, 8'h00}},
        '{MODE_ENQUEUE, 16'h0008, 8'hFE, 1'b0, '{ST_ENQUEUED, 16'h0000, 8'h00}},
        '{MODE_ENQUEUE, 16'h0010, 8'h7F, 1'b0, '{ST_ENQUEUED, 16'h0000, 8'h00}},
        '{MODE_ENQUEUE, 16'h0020, 8'h00, 1'b0, '{ST_ENQUEUED, 16'h0000, 8'h00}},
        '{MODE_ENQUEUE, 16'h0040, 8'hFF, 1'b0, '{ST_ENQUEUED, 16'h0000, 8'h00}},
        '{MODE_ENQUEUE, 16'h0080, 8'h80, 1'b0, '{ST_ENQUEUED, 16'h0000, 8'h00}},
        '{MODE_ENQUEUE, 16'h0100, 8'h55, 1'b0, '{ST_ENQUEUED, 16'h0000, 8'h00}},
        '{MODE_ENQUEUE, 16'h0200, 8'hAA, 1'b0, '{ST_ENQUEUED, 16'h0000, 8'h00}},
        '{MODE_ENQUEUE, 16'h0400, 8'h01, 1'b0, '{ST_ENQUEUED, 16'h0000, 8'h00}},
        '{MODE_ENQUEUE, 16'h0800, 8'h10, 1'b0, '{ST_ENQUEUED, 16'h0000, 8'h00}},
        '{MODE_ENQUEUE, 16'h1000, 8'h80, 1'b0, '{ST_ENQUEUED, 16'h0000, 8'h00}},
        '{MODE_ENQUEUE, 16'h2000, 8'hC3, 1'b0, '{ST_ENQUEUED, 16'h0000, 8'h00}},
        '{MODE_ENQUEUE, 16'h4000, 8'h3C, 1'b0, '{ST_ENQUEUED, 16'h0000, 8'h00}},
        '{MODE_ENQUEUE, 16'h8000, 8'hFF, 1'b0, '{ST_ENQUEUED, 16'h0000, 8'h00}},
        '{MODE_ENQUEUE, 16'hBEEF, 8'hFF, 1'b1, '{ST_FULL,     16'h0000, 8'h00}}
    };

    stable_priority_queue_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic queue_result_t queue_step(mode_t mode, logic [ID_W-1:0] id,
                                                 logic [PRIO_W-1:0] prio);
        queue_result_t r;
        int            pos;
        r = '{status: ST_ENQUEUED, id: '0, prio: '0};
        if (mode == MODE_ENQUEUE)
        begin
            if (model_fill >= QUEUE_DEPTH)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                pos = model_fill;
                for (int i = 0; i < model_fill; i++)
                begin
                    if (model_prio[i] < prio)
                    begin
                        pos = i;
                        break;
                    end
                end
                for (int i = model_fill; i > pos; i--)
                begin
                    model_id[i]   = model_id[i-1];
                    model_prio[i] = model_prio[i-1];
                end
                model_id[pos]   = id;
                model_prio[pos] = prio;
                model_fill++;
            end
        end
        else if (model_fill == 0)
        begin
            r.status = ST_EMPTY;
        end
        else
        begin
            r.status = ST_DEQUEUED;
            r.id     = model_id[0];
            r.prio   = model_prio[0];
            for (int i = 1; i < model_fill; i++)
            begin
                model_id[i-1]   = model_id[i];
                model_prio[i-1] = model_prio[i];
            end
            model_fill--;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t ns: %s mismatch: got %h, expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    // input beat accepted: predict, output beat accepted: check
    always @(posedge clk)
    begin
        queue_result_t want;
        queue_result_t got;
        queue_result_t predicted;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.status = status_t'(m_axis_tdata[1:0]);
                got.id     = m_axis_tdata[17:2];
                got.prio   = m_axis_tdata[25:18];
                if (pending_wr == pending_rd)
                begin
                    report_mismatch("unexpected result beat", m_axis_tdata, '0);
                end
                else
                begin
                    want = pending_results[pending_rd % PENDING_DEPTH];
                    pending_rd++;
                    if (got.status !== want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.id !== want.id)
                        report_mismatch("out_id", got.id, want.id);
                    if (got.prio !== want.prio)
                        report_mismatch("out_priority", got.prio, want.prio);
                    if (m_axis_tdata[31:26] !== '0)
                        report_mismatch("zero fill", m_axis_tdata[31:26], '0);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                predicted = queue_step(mode_t'(s_axis_tdata[0]), s_axis_tdata[16:1],
                                       s_axis_tdata[24:17]);
                pending_results[pending_wr % PENDING_DEPTH] =
                    beat_fixed ? beat_want : predicted;
                pending_wr++;
            end
        end
    end

    // result side backpressure
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 3) == 0)
        begin
            stall_left    <= $urandom_range(0, 2);
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    // called and returns at a falling edge
    task automatic send_op(mode_t mode, logic [ID_W-1:0] id, logic [PRIO_W-1:0] prio,
                           bit fixed, queue_result_t want);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, prio, id, mode};
        beat_fixed    <= fixed;
        beat_want     <= want;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    initial
    begin
        int            sent;
        int            chunk_len;
        int            enq_pct;
        int            prio_kind;
        logic [7:0]    prio;
        mode_t         mode;
        queue_result_t none;
        none           = '{status: ST_ENQUEUED, id: '0, prio: '0};
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        m_axis_tready  = 1'b0;
        beat_fixed     = 1'b0;
        beat_want      = none;
        idle_on        = 1'b0;
        stall_left     = 0;
        mismatch_count = 0;
        model_fill     = 0;
        pending_wr     = 0;
        pending_rd     = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        idle_on = 1'b1;
        foreach (directed_rows[i])
        begin
            send_op(directed_rows[i].mode, directed_rows[i].id, directed_rows[i].prio,
                    directed_rows[i].fixed, directed_rows[i].want);
        end

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            chunk_len = $urandom_range(20, 60);
            case ($urandom_range(0, 2))
                0: enq_pct = 85;
                1: enq_pct = 50;
                default: enq_pct = 15;
            endcase
            prio_kind = $urandom_range(0, 2);
            // calm tail, and the odd calm stretch before it
            idle_on = (RANDOM_ITEMS - sent > 150) && ($urandom_range(0, 3) != 0);
            for (int k = 0; k < chunk_len && sent < RANDOM_ITEMS; k++)
            begin
                mode = ($urandom_range(0, 99) < enq_pct) ? MODE_ENQUEUE : MODE_DEQUEUE;
                case (prio_kind)
                    0: prio = $urandom_range(0, 255);
                    1: prio = $urandom_range(0, 3);
                    default: prio = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                endcase
                send_op(mode, $urandom_range(0, 65535), prio, 1'b0, none);
                sent++;
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending_wr != pending_rd)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && pending_wr == pending_rd)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial
    begin
        #1000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
